### rtl/mwo_pkg.sv
// Package for the morphing wavetable oscillator: table geometry, fixed-point
// constants, waveform codes, the sine fill port type and small helper functions.
// No dependencies.
package mwo_pkg;

   localparam int TABLE_SIZE = 2048;
   localparam int TABLE_BITS = $clog2(TABLE_SIZE);
   localparam int NUM_TERMS  = 6;

   localparam logic [15:0] POS_MAX = 16'd49152;

   localparam logic [1:0] WAVE_SINE   = 2'd0;
   localparam logic [1:0] WAVE_TRI    = 2'd1;
   localparam logic [1:0] WAVE_SAW    = 2'd2;
   localparam logic [1:0] WAVE_SQUARE = 2'd3;

   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [32:0] PI_Q30      = 33'd3373259426;
   localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

   typedef struct packed {
      logic                  busy;
      logic                  wr_en;
      logic [TABLE_BITS-1:0] addr;
      logic [15:0]           data;
   } fill_port_type;

   typedef struct packed {
      logic [1:0]  pre;
      logic [31:0] mul;
      logic [5:0]  post;
   } recip_type;

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      if (v > 34'sd32767) begin
         return 16'sd32767;
      end else if (v < -34'sd32768) begin
         return -16'sd32768;
      end
      return v[15:0];
   endfunction

   // Taylor series divisors, innermost term first: the even factor is shifted out,
   // the odd factor is a reciprocal multiply and shift, exact for the dividend range
   function automatic recip_type taylor_recip(input logic [2:0] k);
      recip_type r;
      unique case (k)
         3'd0: r = '{pre: 2'd2, mul: 32'd3524075731, post: 6'd37};
         3'd1: r = '{pre: 2'd1, mul: 32'd2498890064, post: 6'd37};
         3'd2: r = '{pre: 2'd3, mul: 32'd3817748708, post: 6'd35};
         3'd3: r = '{pre: 2'd1, mul: 32'd3272356036, post: 6'd36};
         3'd4: r = '{pre: 2'd2, mul: 32'd3435973837, post: 6'd34};
         3'd5: r = '{pre: 2'd1, mul: 32'd2863311531, post: 6'd33};
         default: r = '{pre: 2'd0, mul: 32'd0, post: 6'd0};
      endcase
      return r;
   endfunction

   // Triangle, saw and square entries are generated from the index
   function automatic logic signed [15:0] wave_gen(input logic [1:0] wave,
                                                   input logic [TABLE_BITS-1:0] i);
      logic [TABLE_BITS+17:0] t4;
      logic [TABLE_BITS+16:0] t2;
      logic                   first;
      logic signed [18:0]     v;
      first = !i[TABLE_BITS-1];
      t4 = ({1'b0, i, 17'b0} + (TABLE_BITS+18)'(TABLE_SIZE / 2)) >> TABLE_BITS;
      t2 = ({1'b0, i, 16'b0} + (TABLE_BITS+17)'(TABLE_SIZE / 2)) >> TABLE_BITS;
      unique case (wave)
         WAVE_TRI: begin
            if (first) begin
               v = $signed({1'b0, t4[17:0]}) - 19'sd32768;
            end else begin
               v = 19'sd98304 - $signed({1'b0, t4[17:0]});
            end
         end
         WAVE_SAW:    v = $signed({2'b00, t2[16:0]}) - 19'sd32768;
         WAVE_SQUARE: v = first ? 19'sd32767 : -19'sd32768;
         WAVE_SINE:   v = 19'sd0;
      endcase
      return sat16(34'(v));
   endfunction

endpackage

### rtl/mwo_sine_fill.sv
// Sine table fill engine: computes the Q1.15 sine entries one at a time after reset
// with a Taylor series in Q30; constant divisions are reciprocal multiplications.
// Depends on mwo_pkg.
module mwo_sine_fill
   import mwo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   output fill_port_type fill
);

   localparam int ACC_W = 33 + TABLE_BITS;

   localparam logic [2:0] ST_X    = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_T    = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;
   localparam logic [2:0] ST_WR   = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [TABLE_BITS-1:0] idx_ff, idx_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [30:0]           x_ff, x_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           x2_ff, x2_in;
   logic [30:0]           t_ff, t_in;
   logic [2:0]            k_ff, k_in;
   logic [31:0]           dq_ff, dq_in;
   logic [30:0]           s_ff, s_in;

   logic [ACC_W-1:0] rnd;
   logic [32:0]      x0, x1, xh, xf;
   logic             neg_x;
   logic [61:0]      sq_prod;
   logic [62:0]      tx_prod;
   logic [61:0]      xt_prod;
   recip_type        rc;
   logic [31:0]      dsh;
   logic [63:0]      dprod, dquo;
   logic [31:0]      q_sum;
   logic [16:0]      q17;
   logic [15:0]      q_sat;

   always_comb begin
      rnd   = acc_ff + ACC_W'(TABLE_SIZE / 2);
      x0    = rnd[TABLE_BITS +: 33];
      x1    = (x0 >= TWO_PI_Q30) ? x0 - TWO_PI_Q30 : x0;
      neg_x = x1 >= PI_Q30;
      xh    = neg_x ? x1 - PI_Q30 : x1;
      if (xh > HALF_PI_Q30) begin
         xf = (xh > PI_Q30) ? 33'd0 : PI_Q30 - xh;
      end else begin
         xf = xh;
      end
      sq_prod   = x_ff * x_ff;
      tx_prod   = x2_ff * t_ff;
      xt_prod   = x_ff * t_ff;
      rc        = taylor_recip(k_ff);
      dsh       = dq_ff >> rc.pre;
      dprod     = dsh * rc.mul;
      dquo      = dprod >> rc.post;
      q_sum     = {1'b0, s_ff} + 32'd16384;
      q17       = q_sum[31:15];
      q_sat     = (q17 > 17'd32767) ? 16'd32767 : q17[15:0];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      neg_in   = neg_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      dq_in    = dq_ff;
      s_in     = s_ff;
      unique case (state_ff)
         ST_X: begin
            x_in     = xf[30:0];
            neg_in   = neg_x;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            x2_in    = sq_prod[61:30];
            t_in     = Q30_ONE;
            k_in     = 3'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            dq_in    = tx_prod[61:30];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dq_in    = dquo[31:0];
            state_in = ST_T;
         end
         ST_T: begin
            t_in = (dq_ff >= {1'b0, Q30_ONE}) ? 31'd0 : Q30_ONE - dq_ff[30:0];
            if (k_ff == 3'(NUM_TERMS - 1)) begin
               state_in = ST_OUT;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            s_in     = xt_prod[60:30];
            state_in = ST_WR;
         end
         ST_WR: begin
            if (idx_ff == TABLE_BITS'(TABLE_SIZE - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + TABLE_BITS'(1);
               acc_in   = acc_ff + ACC_W'(TWO_PI_Q30);
               state_in = ST_X;
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_X;
         idx_ff   <= '0;
         acc_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      neg_ff <= neg_in;
      x2_ff  <= x2_in;
      t_ff   <= t_in;
      dq_ff  <= dq_in;
      s_ff   <= s_in;
   end

   always_comb begin
      fill.busy  = state_ff != ST_DONE;
      fill.wr_en = state_ff == ST_WR;
      fill.addr  = idx_ff;
      fill.data  = neg_ff ? 16'd0 - q_sat : q_sat;
   end

endmodule

### rtl/morphing_wavetable_oscillator_top.sv
// Morphing wavetable oscillator, top level: sine table memory, six-stage
// interpolate and morph pipeline, morph position register.
// Depends on mwo_pkg and mwo_sine_fill.
//
// Usage:
//  - req channel: one word per phase (req_phase, unsigned 32-bit cycle fraction),
//    taken at a clock edge with req_valid high and req_stall low.
//  - rsp channel: one word per accepted phase (rsp_sample, signed Q1.15), in order,
//    taken at a clock edge with rsp_valid high and rsp_stall low.
//  - csr port: csr_wr_en writes csr_wr_data as the Q2.14 morph position
//    (0 sine, 1.0 triangle, 2.0 saw, 3.0 square; larger values act as 3.0).
//    Write only while no word is in flight.
//  - Path: an accepted word moves through stages 1 to 6; rsp_valid is the stage 6 valid bit.
//  - Throughput: one word per cycle while rsp_stall is low and the fill is done; every
//    stage has its own valid bit and advances whenever the stage after it is empty or moving, so bubbles close up.
//  - Reset: clears the pipeline and sets the morph position to 0, then the sine
//    table is computed one entry at a time (2048 entries),
//    during which req_stall is held high. csr writes are taken as usual.
//  - A stalled rsp holds its word; stall then backs up stage by stage to req_stall.
module morphing_wavetable_oscillator_top
   import mwo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_phase,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   fill_port_type fill;

   mwo_sine_fill u_fill (
      .clock (clock),
      .reset (reset),
      .fill  (fill)
   );

   logic [15:0] sine_mem [TABLE_SIZE];

   logic [15:0] pos_ff, pos_in;
   logic [1:0]  wl, wh;
   logic [13:0] w;

   logic en1, en2, en3, en4, en5, en6;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   logic [TABLE_BITS-1:0] idx1_ff, nxt1;
   logic [15:0]           frac1_ff, frac2_ff;
   logic [15:0]           sa2_ff, sb2_ff;
   logic signed [15:0]    la2_ff, lb2_ff, ha2_ff, hb2_ff;
   logic                  lsine2_ff;

   logic signed [15:0] lo_a, lo_b;
   logic signed [16:0] dlo, dhi;
   logic signed [33:0] plo3_in, phi3_in, plo3_ff, phi3_ff;
   logic signed [15:0] alo3_ff, ahi3_ff;

   logic signed [33:0] slo, shi;
   logic signed [15:0] lo4_ff, hi4_ff;

   logic signed [16:0] dm;
   logic signed [31:0] m5_in, m5_ff;
   logic signed [15:0] lo5_ff;

   logic signed [33:0] s6;
   logic signed [15:0] sample_ff;

   // morph position, stored clamped
   always_comb begin
      pos_in = (csr_wr_data > POS_MAX) ? POS_MAX : csr_wr_data;
      wl     = pos_ff[15:14];
      wh     = (wl == WAVE_SQUARE) ? WAVE_SQUARE : wl + 2'd1;
      w      = pos_ff[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (csr_wr_en) begin
         pos_ff <= pos_in;
      end
   end

   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall  = fill.busy || !en1;
   assign rsp_valid  = v6_ff;
   assign rsp_sample = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid && !fill.busy;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // sine table: one write port for the fill, two registered read ports
   always_ff @(posedge clock) begin
      if (fill.wr_en) begin
         sine_mem[fill.addr] <= fill.data;
      end
   end

   assign nxt1 = idx1_ff + TABLE_BITS'(1);

   always_ff @(posedge clock) begin
      if (en2) begin
         sa2_ff <= sine_mem[idx1_ff];
         sb2_ff <= sine_mem[nxt1];
      end
   end

   // stage 1: table index and interpolation fraction
   always_ff @(posedge clock) begin
      if (en1) begin
         idx1_ff  <= req_phase[31 -: TABLE_BITS];
         frac1_ff <= req_phase[31-TABLE_BITS -: 16];
      end
   end

   // stage 2: generated waveform entries
   always_ff @(posedge clock) begin
      if (en2) begin
         la2_ff    <= wave_gen(wl, idx1_ff);
         lb2_ff    <= wave_gen(wl, nxt1);
         ha2_ff    <= wave_gen(wh, idx1_ff);
         hb2_ff    <= wave_gen(wh, nxt1);
         lsine2_ff <= wl == WAVE_SINE;
         frac2_ff  <= frac1_ff;
      end
   end

   // stage 3: interpolation products
   always_comb begin
      lo_a    = lsine2_ff ? $signed(sa2_ff) : la2_ff;
      lo_b    = lsine2_ff ? $signed(sb2_ff) : lb2_ff;
      dlo     = lo_b - lo_a;
      dhi     = hb2_ff - ha2_ff;
      plo3_in = dlo * $signed({1'b0, frac2_ff});
      phi3_in = dhi * $signed({1'b0, frac2_ff});
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         alo3_ff <= lo_a;
         ahi3_ff <= ha2_ff;
         plo3_ff <= plo3_in;
         phi3_ff <= phi3_in;
      end
   end

   // stage 4: round and add
   always_comb begin
      slo = alo3_ff + ((plo3_ff + 34'sd32768) >>> 16);
      shi = ahi3_ff + ((phi3_ff + 34'sd32768) >>> 16);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         lo4_ff <= sat16(slo);
         hi4_ff <= sat16(shi);
      end
   end

   // stage 5: morph product
   always_comb begin
      dm    = hi4_ff - lo4_ff;
      m5_in = dm * $signed({1'b0, w});
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         lo5_ff <= lo4_ff;
         m5_ff  <= m5_in;
      end
   end

   // stage 6: output word
   assign s6 = lo5_ff + ((34'(m5_ff) + 34'sd8192) >>> 14);

   always_ff @(posedge clock) begin
      if (en6) begin
         sample_ff <= sat16(s6);
      end
   end

endmodule

### tb/mwo_sample_check.sv
// Sample predictor and scoreboard for the morphing wavetable oscillator: watches the
// phase, sample and morph register ports, predicts each sample and compares in order.
// Depends on mwo_pkg for the table size, waveform codes and morph limit.
module mwo_sample_check
   import mwo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [31:0]        req_phase,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_sample,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output int                 mismatch_count,
   output int                 samples_in_flight
);

   localparam longint unsigned ANGLE_2PI     = 64'd6746518852;
   localparam longint unsigned ANGLE_PI      = 64'd3373259426;
   localparam longint unsigned ANGLE_HALF_PI = 64'd1686629713;
   localparam longint unsigned UNIT_Q30      = 64'd1073741824;
   localparam int              MAX_PRINTED   = 40;

   typedef struct {
      logic [31:0]        phase;
      logic [15:0]        morph;
      logic signed [15:0] sample;
   } expected_word_type;

   logic signed [15:0] wave_table [0:3][0:TABLE_SIZE-1];
   logic [15:0]        morph_reg;
   expected_word_type  expected_samples [$];

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // floor(v / 2^sh + 1/2)
   function automatic longint half_up(input longint v, input int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [15:0] sine_entry(input int i);
      longint unsigned x, x2, term, d, s, q;
      logic            neg;
      int              k, m;
      x = (ANGLE_2PI * 64'(i) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
      neg = 1'b0;
      if (x >= ANGLE_2PI) x -= ANGLE_2PI;
      if (x >= ANGLE_PI) begin
         neg = 1'b1;
         x -= ANGLE_PI;
      end
      if (x > ANGLE_HALF_PI) x = (x > ANGLE_PI) ? 64'd0 : ANGLE_PI - x;
      x2 = (x * x) >> 30;
      term = UNIT_Q30;
      // Horner form of the Taylor series, divisors 13*12 down to 3*2
      for (k = 0; k < 6; k++) begin
         m = 12 - 2 * k;
         d = ((x2 * term) >> 30) / 64'(m * (m + 1));
         term = (d >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - d;
      end
      s = (x * term) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      return neg ? 16'(-q) : 16'(q);
   endfunction

   function automatic longint lerp(input logic [1:0] wave, input int idx, input int nxt,
                                   input longint frac);
      longint a, b;
      a = wave_table[wave][idx];
      b = wave_table[wave][nxt];
      return clamp16(a + half_up((b - a) * frac, 16));
   endfunction

   function automatic logic signed [15:0] predict_sample(input logic [31:0] ph,
                                                         input logic [15:0] morph);
      longint unsigned prod;
      int              idx, nxt;
      longint          frac, w, lo, hi;
      logic [15:0]     pos;
      logic [1:0]      lo_wave, hi_wave;
      prod = 64'(ph) * 64'(TABLE_SIZE);
      idx = int'(prod >> 32);
      frac = longint'((prod >> 16) & 64'hFFFF);
      if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
      nxt = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
      pos = (morph > POS_MAX) ? POS_MAX : morph;
      lo_wave = pos[15:14];
      hi_wave = (lo_wave == WAVE_SQUARE) ? WAVE_SQUARE : lo_wave + 2'd1;
      w = longint'(pos[13:0]);
      lo = lerp(lo_wave, idx, nxt, frac);
      hi = lerp(hi_wave, idx, nxt, frac);
      return clamp16(lo + half_up((hi - lo) * w, 14));
   endfunction

   task automatic report_mismatch(input string what, input expected_word_type want,
                                  input logic signed [15:0] got);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t: %s: phase=%h morph=%h got=%0d expected=%0d",
                  $time, what, want.phase, want.morph, got, want.sample);
      end
      mismatch_count++;
   endtask

   initial begin
      int     i;
      longint t4, t2;
      bit     first;
      for (i = 0; i < TABLE_SIZE; i++) begin
         first = (2 * i) < TABLE_SIZE;
         t4 = (longint'(i) * 131072 + TABLE_SIZE / 2) / TABLE_SIZE;
         t2 = (longint'(i) * 65536 + TABLE_SIZE / 2) / TABLE_SIZE;
         wave_table[WAVE_SINE][i]   = sine_entry(i);
         wave_table[WAVE_TRI][i]    = clamp16(first ? t4 - 32768 : 98304 - t4);
         wave_table[WAVE_SAW][i]    = clamp16(t2 - 32768);
         wave_table[WAVE_SQUARE][i] = first ? 16'sh7FFF : 16'sh8000;
      end
   end

   always @(posedge clock) begin
      expected_word_type head;
      expected_word_type stray;
      if (reset) begin
         morph_reg = '0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               stray.phase = 'x;
               stray.morph = morph_reg;
               stray.sample = 'x;
               report_mismatch("sample word with no phase outstanding", stray, rsp_sample);
            end else begin
               head = expected_samples.pop_front();
               if (rsp_sample !== head.sample) begin
                  report_mismatch("sample mismatch", head, rsp_sample);
               end
            end
         end
         if (csr_wr_en) morph_reg = csr_wr_data;
         if (req_valid && !req_stall) begin
            head.phase = req_phase;
            head.morph = morph_reg;
            head.sample = predict_sample(req_phase, morph_reg);
            expected_samples.push_back(head);
         end
      end
      samples_in_flight = expected_samples.size();
   end

endmodule

### tb/tb_morphing_wavetable_oscillator_top.sv
// Testbench top for the morphing wavetable oscillator: clock, reset, phase stimulus,
// morph register writes and random stalls; verdict from mwo_sample_check.
// Depends on mwo_pkg, morphing_wavetable_oscillator_top and mwo_sample_check.
module tb_morphing_wavetable_oscillator_top;
   import mwo_pkg::*;

   localparam logic [15:0] MORPH_SINE   = 16'd0;
   localparam logic [15:0] MORPH_TRI    = 16'd16384;
   localparam logic [15:0] MORPH_SAW    = 16'd32768;
   localparam logic [15:0] MORPH_SQUARE = POS_MAX;
   localparam logic [15:0] MORPH_ALL    = 16'hFFFF;
   localparam int          HOLD_CYCLES  = 150;
   localparam int          TAIL_CYCLES  = 12;
   localparam int          LIMIT_CYCLES = 2_500_000;
   localparam int          RAND_BURSTS  = 12;
   localparam int          BURST_WORDS  = 100;
   localparam int          LOW_BITS     = 32 - TABLE_BITS - 16;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_phase = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;
   int                 mismatch_count;
   int                 samples_in_flight;
   bit                 tx_idle = 1'b0;
   bit                 rx_idle = 1'b0;
   bit                 hold_request = 1'b0;

   always #5 clock = ~clock;

   morphing_wavetable_oscillator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_phase   (req_phase),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mwo_sample_check sample_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_phase         (req_phase),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .samples_in_flight (samples_in_flight)
   );

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] directed_phase(input int n);
      case (n)
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'hFFE0_0000;  // last entry, no fraction
         5: return 32'hFFF0_0000;  // halfway from last entry back to entry 0
         6: return 32'h0010_0000;  // half-LSB rounding
         default: return 32'h4000_0020;
      endcase
   endfunction

   function automatic logic [15:0] burst_morph(input int k);
      case (k)
         0: return MORPH_TRI;
         1: return MORPH_SAW;
         2: return 16'd8192;
         3: return 16'd24577;
         4: return 16'd49151;
         5: return 16'd49153;
         6: return MORPH_SINE;
         7: return MORPH_ALL;
         8: return 16'd40961;
         9: return 16'($urandom_range(0, 49152));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_phase();
      logic [TABLE_BITS-1:0] idx;
      logic [15:0]           frac;
      idx = TABLE_BITS'($urandom);
      frac = 16'($urandom);
      case ($urandom_range(0, 5))
         0, 1, 2: return $urandom;
         3: idx = $urandom_range(0, 1) ? '1 : '0;
         4: begin
            case ($urandom_range(0, 3))
               0: frac = 16'h0000;
               1: frac = 16'h8000;
               2: frac = 16'h7FFF;
               default: frac = 16'hFFFF;
            endcase
         end
         default: begin
            idx = $urandom_range(0, 1) ? '1 : '0;
            frac = $urandom_range(0, 1) ? 16'h8000 : 16'hFFFF;
         end
      endcase
      return {idx, frac, LOW_BITS'($urandom)};
   endfunction

   task automatic write_morph(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_phase(input logic [31:0] ph);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_phase <= ph;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_in_flight != 0) @(posedge clock);
   endtask

   // Sample receiver
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_len()) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int k, n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < 3; k++) begin
         write_morph(k == 0 ? MORPH_SINE : (k == 1 ? MORPH_SQUARE : MORPH_ALL));
         for (n = 0; n < 8; n++) send_phase(directed_phase(n));
         drain_words();
      end

      for (k = 0; k < RAND_BURSTS; k++) begin
         write_morph(burst_morph(k));
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         if (k == 3) begin
            tx_idle = 1'b0;
            hold_request = 1'b1;
         end
         if (k == 7) begin
            tx_idle = 1'b0;
            rx_idle = 1'b0;
         end
         for (n = 0; n < BURST_WORDS; n++) send_phase(pick_phase());
         drain_words();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && samples_in_flight == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
rtl/mwo_pkg.sv
rtl/mwo_sine_fill.sv
rtl/morphing_wavetable_oscillator_top.sv
tb/mwo_sample_check.sv
tb/tb_morphing_wavetable_oscillator_top.sv
